// ----- design/ewgat_pkg.sv -----
package ewgat_pkg;

  // Field widths
  localparam int ANGLE_W   = 13;
  localparam int CURRENT_W = 16;
  localparam int THR_W     = 14;
  localparam int RATIO_W   = 8;
  localparam int GEARED_W  = 14;
  localparam int OUT_W     = 15;
  localparam int CFG_IDX_W = 1;

  localparam int ANGLE_MAX          = (1 << ANGLE_W) - 1;
  localparam int RATIO_MAX          = (1 << RATIO_W) - 1;
  localparam int THRESHOLD_SEED     = 1200;
  localparam int DEF_COUNTS_PER_REV = 8192;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO     = 1'd1;

  // Bits needed for angle plus counts-per-rev times the largest turn index
  function automatic int dividend_width(input int cpr);
    return $clog2(ANGLE_MAX + cpr * (RATIO_MAX - 1) + 1);
  endfunction

  localparam int DEF_DIVIDEND_W = dividend_width(DEF_COUNTS_PER_REV);

  typedef struct packed {
    logic        [ANGLE_W-1:0]   raw_angle;
    logic signed [CURRENT_W-1:0] raw_current;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]     output_angle;
    logic signed [CURRENT_W-1:0] motor_current;
  } result_t;

endpackage

// ----- design/encoder_wrap_gear_angle_tracker.sv -----
// Multi-turn encoder tracker with gear reduction.
// Channels: sample (valid/ready) carries one feedback sample, raw angle and
// current; result (valid/ready) carries the geared output angle and the
// current passed through. Configuration is a plain write port: cfg_we,
// cfg_index (0 = wrap threshold, 1 = gear ratio) and cfg_data, taken at
// once; write it only while the block is idle.
// One sample is worked on at a time: it is taken in, the turn index is
// updated, the one-bit-per-cycle restoring divider is started and run, and
// the geared wrap is applied as the result register is written. A new sample is
// taken once the previous one has reached the result register, so a result
// can wait for the receiver while the next sample is divided; a stalled
// receiver holds the block only when the next result is ready to leave.
// Reset: threshold goes to 1200 minus counts per rev, ratio to 1, the
// previous angles and the turn index to zero, and no result is pending.
module encoder_wrap_gear_angle_tracker
  import ewgat_pkg::*;
#(
  parameter int COUNTS_PER_REV = DEF_COUNTS_PER_REV
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  localparam int DIVIDEND_W = dividend_width(COUNTS_PER_REV);
  localparam logic [THR_W-1:0] THR_RST = THR_W'(THRESHOLD_SEED - COUNTS_PER_REV);
  localparam logic [OUT_W-1:0] CPR_OUT = OUT_W'(COUNTS_PER_REV);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TURN,
    S_LOAD,
    S_DIV,
    S_FIX
  } state_t;

  state_t state;

  logic [THR_W-1:0]     wrap_threshold;
  logic [RATIO_W-1:0]   gear_ratio;
  logic [ANGLE_W-1:0]   prev_raw;
  logic [RATIO_W-1:0]   turn_index;
  logic [GEARED_W-1:0]  prev_geared;
  logic [ANGLE_W-1:0]   raw_q;
  logic [CURRENT_W-1:0] cur_q;
  logic [GEARED_W-1:0]  geared_q;

  logic [RATIO_W-1:0]    ratio;
  logic [RATIO_W-1:0]    ti_base;
  logic [RATIO_W-1:0]    turn_index_next;
  logic signed [ANGLE_W+1:0]  raw_diff_fwd;
  logic signed [ANGLE_W+1:0]  raw_diff_bwd;
  logic signed [ANGLE_W+1:0]  thr_raw;
  logic signed [GEARED_W+1:0] g_diff_fwd;
  logic signed [GEARED_W+1:0] g_diff_bwd;
  logic signed [GEARED_W+1:0] thr_g;
  logic [OUT_W-1:0]      angle_next;
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVIDEND_W-1:0] quotient;

  // A zero ratio behaves as one
  assign ratio = (gear_ratio == '0) ? RATIO_W'(1) : gear_ratio;

  // Raw wrap test and turn index update
  always_comb begin
    ti_base      = (turn_index >= ratio) ? '0 : turn_index;
    thr_raw      = {wrap_threshold[THR_W-1], wrap_threshold};
    raw_diff_fwd = $signed({2'b00, raw_q}) - $signed({2'b00, prev_raw});
    raw_diff_bwd = $signed({2'b00, prev_raw}) - $signed({2'b00, raw_q});
    priority if (raw_diff_fwd < thr_raw) begin
      turn_index_next = ({1'b0, ti_base} + 9'd1 >= {1'b0, ratio}) ? '0
                        : ti_base + RATIO_W'(1);
    end else if (raw_diff_bwd < thr_raw) begin
      turn_index_next = (ti_base == '0) ? ratio - RATIO_W'(1) : ti_base - RATIO_W'(1);
    end else begin
      turn_index_next = ti_base;
    end
  end

  // Angle plus whole revolutions for the divider
  assign div_start = (state == S_LOAD);
  assign dividend  = DIVIDEND_W'(raw_q)
                   + DIVIDEND_W'(COUNTS_PER_REV) * DIVIDEND_W'(turn_index);

  ewgat_sdiv #(
    .DIVIDEND_W (DIVIDEND_W)
  ) u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (ratio),
    .done     (div_done),
    .quotient (quotient)
  );

  // Geared wrap test: add one revolution, remove one, or leave the angle as it is
  always_comb begin
    thr_g      = {{2{wrap_threshold[THR_W-1]}}, wrap_threshold};
    g_diff_fwd = $signed({2'b00, geared_q}) - $signed({2'b00, prev_geared});
    g_diff_bwd = $signed({2'b00, prev_geared}) - $signed({2'b00, geared_q});
    priority if (g_diff_fwd < thr_g) begin
      angle_next = {1'b0, geared_q} + CPR_OUT;
    end else if (g_diff_bwd < thr_g) begin
      angle_next = {1'b0, geared_q} - CPR_OUT;
    end else begin
      angle_next = {1'b0, geared_q};
    end
  end

  assign sample_ready = (state == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_threshold <= THR_RST;
      gear_ratio     <= RATIO_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WRAP_THRESHOLD: wrap_threshold <= cfg_data;
        REG_GEAR_RATIO:     gear_ratio     <= cfg_data[RATIO_W-1:0];
        default:            ;
      endcase
    end
  end

  // Sequencer, tracking state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prev_raw     <= '0;
      turn_index   <= '0;
      prev_geared  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            raw_q <= sample.raw_angle;
            cur_q <= sample.raw_current;
            state <= S_TURN;
          end
        end
        S_TURN: begin
          turn_index <= turn_index_next;
          prev_raw   <= raw_q;
          state      <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            geared_q <= quotient[GEARED_W-1:0];
            state    <= S_FIX;
          end
        end
        S_FIX: begin
          // Hold until the result register is free
          if (!result_valid || result_ready) begin
            result.output_angle  <= angle_next;
            result.motor_current <= cur_q;
            result_valid         <= 1'b1;
            prev_geared          <= geared_q;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside the divide phase");

  // Turn index stays below the ratio once updated
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> turn_index < ratio)
    else $error("turn index not below gear ratio");

  // A new result appears only from the final phase
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_FIX)
    else $error("result raised outside the final phase");

endmodule

// ----- design/ewgat_sdiv.sv -----
module ewgat_sdiv
  import ewgat_pkg::*;
#(
  parameter int DIVIDEND_W = DEF_DIVIDEND_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [RATIO_W-1:0]    divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] sh;
  logic [RATIO_W-1:0]    rem;
  logic [RATIO_W-1:0]    rem_next;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [RATIO_W:0]      trial;
  logic [RATIO_W:0]      diff;
  logic                  fits;

  // Restoring step: bring down one dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, sh[DIVIDEND_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    rem_next = fits ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
  end

  // Shift quotient bits in behind the dividend, one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= dividend;
        rem  <= '0;
        cnt  <= CNT_W'(DIVIDEND_W);
        busy <= 1'b1;
      end else if (busy) begin
        sh  <= {sh[DIVIDEND_W-2:0], fits};
        rem <= rem_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = sh;

endmodule

// ----- test/encoder_wrap_gear_angle_tracker_tb.sv -----
`timescale 1ns / 100ps

module encoder_wrap_gear_angle_tracker_tb;
  import ewgat_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int N_RANDOM       = 9;

  // Idle modes of the two channels
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  sample_t              sample       = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_WRAP_THRESHOLD;
  logic [THR_W-1:0]     cfg_data     = '0;

  // Tracker state mirrored for prediction
  logic signed [THR_W-1:0]  trk_threshold = THR_W'(THRESHOLD_SEED - DEF_COUNTS_PER_REV);
  logic [RATIO_W-1:0]       trk_ratio     = 8'd1;
  logic [ANGLE_W-1:0]       trk_prev_raw  = '0;
  logic [RATIO_W-1:0]       trk_turn      = '0;
  logic [GEARED_W-1:0]      trk_prev_gear = '0;

  sample_t    pending_samples[$];
  result_t    expected_results[$];
  idle_mode_t idle_mode     = IDLE_NONE;
  logic       pressure_on   = 1'b0;
  logic       pressure_done = 1'b0;
  int         hold_left     = 0;
  int         err_count     = 0;
  int         quiet_cycles  = 0;
  int         walk_angle    = 0;
  logic       took_sample;
  result_t    want;

  encoder_wrap_gear_angle_tracker uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Work out the geared angle for one sample and advance the tracker state
  function automatic result_t track_sample(sample_t s);
    int          raw;
    int          prev;
    int          prevg;
    int          thr;
    int          geared;
    int          angle_out;
    int unsigned ratio;
    int unsigned idx;
    result_t     r;
    raw   = s.raw_angle;
    prev  = trk_prev_raw;
    prevg = trk_prev_gear;
    thr   = trk_threshold;
    ratio = (trk_ratio == 0) ? 1 : trk_ratio;
    idx   = trk_turn;
    // clear an index left over from a higher ratio
    if (idx >= ratio) idx = 0;
    if (raw - prev < thr) begin
      idx = (idx + 1 >= ratio) ? 0 : idx + 1;
    end else if (prev - raw < thr) begin
      idx = (idx == 0) ? ratio - 1 : idx - 1;
    end
    trk_prev_raw = s.raw_angle;
    trk_turn     = idx[RATIO_W-1:0];
    geared = int'(((raw + DEF_COUNTS_PER_REV * idx) / ratio) & 32'h3FFF);
    if (geared - prevg < thr) begin
      angle_out = geared + DEF_COUNTS_PER_REV;
    end else if (prevg - geared < thr) begin
      angle_out = geared - DEF_COUNTS_PER_REV;
    end else begin
      angle_out = geared;
    end
    trk_prev_gear   = geared[GEARED_W-1:0];
    r.output_angle  = angle_out[OUT_W-1:0];
    r.motor_current = s.raw_current;
    return r;
  endfunction

  function automatic logic sender_pause();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 55;
      IDLE_BOTH:   return $urandom_range(0, 99) < 29;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_pause();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 55;
      IDLE_BOTH:     return $urandom_range(0, 99) < 29;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int wanted);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, wanted);
    err_count++;
  endtask

  task automatic queue_sample(int angle, int current);
    sample_t s;
    s.raw_angle   = angle[ANGLE_W-1:0];
    s.raw_current = current[CURRENT_W-1:0];
    pending_samples.push_back(s);
  endtask

  function automatic int random_current();
    case ($urandom_range(0, 19))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Queue encoder motion: spins that wrap, jitter, and a share of noise
  task automatic queue_motion(int n);
    int left;
    int seg;
    int kind;
    int dir;
    int step;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      seg  = $urandom_range(5, 40);
      dir  = $urandom_range(0, 1) ? 1 : -1;
      if (seg > left) seg = left;
      repeat (seg) begin
        if (kind < 6) begin
          step = dir * int'($urandom_range(600, 1190));
        end else if (kind < 8) begin
          step = int'($urandom_range(0, 600)) - 300;
        end else begin
          step = int'($urandom_range(0, ANGLE_MAX));
        end
        walk_angle = (walk_angle + step) & ANGLE_MAX;
        queue_sample(walk_angle, random_current());
      end
      left -= seg;
    end
  endtask

  // Write one register; only called with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[THR_W-1:0];
    if (idx == REG_WRAP_THRESHOLD) begin
      trk_threshold = value[THR_W-1:0];
    end else begin
      trk_ratio = value[RATIO_W-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued request has gone through and every result is back
  task automatic drain();
    while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Driver: offer pending requests, predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      took_sample = sample_valid && sample_ready;
      if (took_sample) expected_results.push_back(track_sample(sample));
      if (!sample_valid || took_sample) begin
        if (pending_samples.size() != 0 && !sender_pause()) begin
          sample       <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off so the block backs up onto its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (pressure_on && !pressure_done) begin
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each result against the oldest prediction, drive ready
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result angle", result.output_angle, 0);
        end else begin
          want = expected_results.pop_front();
          if (result.output_angle !== want.output_angle)
            report_mismatch("output_angle", result.output_angle, want.output_angle);
          if (result.motor_current !== want.motor_current)
            report_mismatch("motor_current", result.motor_current, want.motor_current);
        end
      end
      if (hold_left > 0) begin
        result_ready <= 1'b0;
      end else begin
        result_ready <= !receiver_pause();
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int thr_tab[N_RANDOM];
    int ratio_tab[N_RANDOM];
    idle_mode_t mode_tab[N_RANDOM];
    thr_tab   = '{-6992, -8192, 8191, -4000, -6992, 0, 0, 0, -1200};
    ratio_tab = '{1, 255, 7, 255, 16, 0, 0, 0, 2};
    mode_tab  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
                  IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // extremes of angle and current under reset settings, wraps both ways
    queue_sample(0, 0);
    queue_sample(ANGLE_MAX, 32767);
    queue_sample(0, -32768);
    queue_sample(4096, 1);
    queue_sample(4095, -1);
    queue_sample(5000, 12345);
    drain();

    // forward wraps count the turn index up
    write_reg(REG_GEAR_RATIO, 3);
    queue_sample(8000, 100);
    queue_sample(100, -100);
    queue_sample(4000, 200);
    queue_sample(8000, -200);
    queue_sample(100, 300);
    drain();

    // lowered ratio leaves a stale index; then a backward wrap from zero
    write_reg(REG_GEAR_RATIO, 2);
    queue_sample(4000, 7);
    queue_sample(0, -7);
    queue_sample(ANGLE_MAX, 77);
    drain();

    // positive threshold: both tests hold and the forward one wins
    write_reg(REG_WRAP_THRESHOLD, 100);
    queue_sample(5000, 1);
    queue_sample(5000, 2);
    queue_sample(5050, 3);
    drain();

    write_reg(REG_WRAP_THRESHOLD, 8191);
    queue_sample(0, 4);
    queue_sample(ANGLE_MAX, 5);
    drain();

    write_reg(REG_WRAP_THRESHOLD, -8192);
    queue_sample(0, 6);
    queue_sample(ANGLE_MAX, 8);
    queue_sample(0, 9);
    drain();

    // zero ratio acts as one
    write_reg(REG_WRAP_THRESHOLD, -6992);
    write_reg(REG_GEAR_RATIO, 0);
    queue_sample(8000, 10);
    queue_sample(100, 11);
    queue_sample(3000, 12);
    drain();

    // random phases, each with its own settings and idle mode
    for (int p = 0; p < N_RANDOM; p++) begin
      if (p >= 5 && p <= 7) begin
        thr_tab[p]   = int'($urandom_range(0, 16383)) - 8192;
        ratio_tab[p] = $urandom_range(1, RATIO_MAX);
      end
      write_reg(REG_WRAP_THRESHOLD, thr_tab[p]);
      write_reg(REG_GEAR_RATIO, ratio_tab[p]);
      idle_mode <= mode_tab[p];
      if (p == 4) pressure_on <= 1'b1;
      queue_motion(103);
      drain();
    end

    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
